/* hdl/bispectrum_triple_product_core_assert.svh */
// Assertion macros for the bispectrum triple-product core.
// Used by hdl/bispectrum_triple_product_core.sv; expects clock and reset in scope.
`ifndef BISPECTRUM_TRIPLE_PRODUCT_CORE_ASSERT_SVH
`define BISPECTRUM_TRIPLE_PRODUCT_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BTP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bispectrum core: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bispectrum core: next-cycle check failed");

`endif

/* hdl/btp_pkg.sv */
// Types, widths and constants of the bispectrum triple-product core.
// No dependencies; imported by hdl/bispectrum_triple_product_core.sv.
package btp_pkg;

   // Field widths
   localparam int COEF_W  = 16;
   localparam int IDX_W   = 10;
   localparam int LEN_W   = 11;
   localparam int SCALE_W = 17;
   localparam int OUT_W   = 48;

   // Stream word layout
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 2;
   localparam int REQ_IDX_LSB  = 0;
   localparam int REQ_RE_LSB   = 10;
   localparam int REQ_IM_LSB   = 26;
   localparam int REQ_F1_LSB   = 42;
   localparam int REQ_F2_LSB   = 52;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SERIES_LENGTH  = 1'b0;
   localparam logic REG_INVERSE_LENGTH = 1'b1;
   localparam logic [LEN_W-1:0]   SERIES_LENGTH_RST  = 11'd1024;
   localparam logic [SCALE_W-1:0] INVERSE_LENGTH_RST = 17'd64;

   // Datapath widths
   localparam int PROD_W = 32;             // one 16x16 product
   localparam int AB_W   = 33;             // X[k1]*X[k2], per part
   localparam int P_W    = 49;             // raw triple product, per part
   localparam int PLO_W  = 25;             // low slice of the raw product
   localparam int PHI_W  = P_W - PLO_W;    // high slice, signed
   localparam int PP_W   = 42;             // slice times scale
   localparam int SUM_W  = 67;             // full raw times scale
   localparam int SHR    = 16;             // Q16 scale shift
   localparam int Q_W    = SUM_W - SHR;    // scaled value before clipping

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] im;
      logic signed [COEF_W-1:0] re;
   } coef_type;

endpackage

/* hdl/bispectrum_triple_product_core.sv */
// Bispectrum triple-product core: coefficient table and pipelined query datapath.
// Depends on hdl/btp_pkg.sv and hdl/bispectrum_triple_product_core_assert.svh.
`include "bispectrum_triple_product_core_assert.svh"

// The core holds a table of MAX_LENGTH complex Q15 coefficients and answers queries
// (k1,k2) with X[k1]*X[k2]*conj(X[k1+k2]) scaled by inverse_length (Q16), floored,
// and clipped to 48 signed bits, with tuser reporting the in-region and saturation
// flags. A request word with tuser low writes one coefficient and gives no response;
// a request word with tuser high is a query and gives exactly one response word.
// Queries outside the triangle k1 < N, k2 <= k1, 2*(k1+k2) < N answer zero with the
// in-region flag clear. One request word is taken every clock cycle while the
// response side keeps up, so a new query can enter before the last one answers.
// The rate is set by the table: it is kept in three copies, each with one write
// and one registered read port, so the three reads of a query happen in the same cycle;
// the complex multiplies and the scaling then run through five register stages.
// A coefficient written by one word is seen by a query taken in any later cycle.
// Entries come up undefined and need no clearing; only written entries may be
// queried. The user must write registers over the APB-style port only while no
// query is in flight; the block itself does not enforce this.
module bispectrum_triple_product_core #(
   parameter int unsigned MAX_LENGTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: coef_index, coef_real, coef_imag, freq_one, freq_two, zero fill
   input  logic [btp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: operation (0 write, 1 query)
   input  logic [btp_pkg::REQ_USER_W-1:0]    req_tuser,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: prod_real, prod_imag
   output logic [btp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser from bit 0: in_region, saturated
   output logic [btp_pkg::RSP_USER_W-1:0]    rsp_tuser,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [btp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [btp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [btp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import btp_pkg::*;

   localparam int AW = $clog2(MAX_LENGTH);
   localparam logic [SCALE_W-1:0] MaxLenV = SCALE_W'(MAX_LENGTH);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [LEN_W-1:0]   series_ff;
   logic [SCALE_W-1:0] inv_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff <= SERIES_LENGTH_RST;
         inv_ff    <= INVERSE_LENGTH_RST;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_SERIES_LENGTH:  series_ff <= csr_pwdata[LEN_W-1:0];
            REG_INVERSE_LENGTH: inv_ff    <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SERIES_LENGTH:  csr_prdata = CSR_DATA_W'(series_ff);
         REG_INVERSE_LENGTH: csr_prdata = CSR_DATA_W'(inv_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Request decode and flow control
   // ---------------------------------------------------------------------------
   // The whole pipeline moves together; it stops only when the response register
   // is full and not being taken.
   logic             rsp_vld_ff;
   logic             adv;
   logic             acc;
   logic             wr_en;
   op_type           op;
   logic [IDX_W-1:0] w_idx;
   coef_type         w_coef;
   logic [IDX_W-1:0] f1;
   logic [IDX_W-1:0] f2;
   logic [IDX_W:0]   ksum;
   logic [LEN_W-1:0] len_eff;
   logic             region_in;

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv && !reset;
   assign acc        = req_tvalid && req_tready;

   assign op        = op_type'(req_tuser[0]);
   assign w_idx     = req_tdata[REQ_IDX_LSB +: IDX_W];
   assign w_coef.re = req_tdata[REQ_RE_LSB +: COEF_W];
   assign w_coef.im = req_tdata[REQ_IM_LSB +: COEF_W];
   assign f1        = req_tdata[REQ_F1_LSB +: IDX_W];
   assign f2        = req_tdata[REQ_F2_LSB +: IDX_W];
   assign ksum      = {1'b0, f1} + {1'b0, f2};

   // Writes beyond the table are dropped.
   assign wr_en = acc && (op == OP_WRITE) && (SCALE_W'(w_idx) < MaxLenV);

   // A length above the table size acts as the table size.
   assign len_eff = (SCALE_W'(series_ff) > MaxLenV) ? LEN_W'(MaxLenV) : series_ff;

   assign region_in = (LEN_W'(f1) < len_eff) && (f2 <= f1) &&
                      ({ksum, 1'b0} < {1'b0, len_eff});

   // ---------------------------------------------------------------------------
   // Stage 1: coefficient table, three copies for three reads per cycle
   // ---------------------------------------------------------------------------
   coef_type mem_a [MAX_LENGTH];
   coef_type mem_b [MAX_LENGTH];
   coef_type mem_c [MAX_LENGTH];
   coef_type a_ff;
   coef_type b_ff;
   coef_type c_ff;
   logic     s1_vld_ff;
   logic     s1_reg_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[AW'(w_idx)] <= w_coef;
         mem_b[AW'(w_idx)] <= w_coef;
         mem_c[AW'(w_idx)] <= w_coef;
      end
      if (adv) begin
         a_ff      <= mem_a[AW'(f1)];
         b_ff      <= mem_b[AW'(f2)];
         c_ff      <= mem_c[AW'(ksum)];
         s1_reg_ff <= region_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= acc && (op == OP_QUERY);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: X[k1] * X[k2]
   // ---------------------------------------------------------------------------
   logic signed [PROD_W-1:0] m_rr;
   logic signed [PROD_W-1:0] m_ii;
   logic signed [PROD_W-1:0] m_ri;
   logic signed [PROD_W-1:0] m_ir;
   logic signed [AB_W-1:0]   abr_in;
   logic signed [AB_W-1:0]   abi_in;
   logic signed [AB_W-1:0]   abr_ff;
   logic signed [AB_W-1:0]   abi_ff;
   coef_type                 c2_ff;
   logic                     s2_vld_ff;
   logic                     s2_reg_ff;

   assign m_rr   = a_ff.re * b_ff.re;
   assign m_ii   = a_ff.im * b_ff.im;
   assign m_ri   = a_ff.re * b_ff.im;
   assign m_ir   = a_ff.im * b_ff.re;
   assign abr_in = AB_W'(m_rr) - AB_W'(m_ii);
   assign abi_in = AB_W'(m_ri) + AB_W'(m_ir);

   always_ff @(posedge clock) begin
      if (adv) begin
         abr_ff    <= abr_in;
         abi_ff    <= abi_in;
         c2_ff     <= c_ff;
         s2_reg_ff <= s1_reg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: times conj(X[k1+k2]); the conjugate folds into the signs below.
   // ---------------------------------------------------------------------------
   logic signed [P_W-1:0] m3_rr;
   logic signed [P_W-1:0] m3_ii;
   logic signed [P_W-1:0] m3_ri;
   logic signed [P_W-1:0] m3_ir;
   logic signed [P_W-1:0] pr_in;
   logic signed [P_W-1:0] pi_in;
   logic signed [P_W-1:0] pr_ff;
   logic signed [P_W-1:0] pi_ff;
   logic                  s3_vld_ff;
   logic                  s3_reg_ff;

   assign m3_rr = abr_ff * c2_ff.re;
   assign m3_ii = abi_ff * c2_ff.im;
   assign m3_ri = abr_ff * c2_ff.im;
   assign m3_ir = abi_ff * c2_ff.re;
   assign pr_in = m3_rr + m3_ii;
   assign pi_in = m3_ir - m3_ri;

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff     <= pr_in;
         pi_ff     <= pi_in;
         s3_reg_ff <= s2_reg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: scale partial products, raw value split into a signed high slice
   // and an unsigned low slice
   // ---------------------------------------------------------------------------
   logic signed [SCALE_W:0] scale_s;
   logic signed [PP_W-1:0]  hi_r_in;
   logic signed [PP_W-1:0]  hi_i_in;
   logic [PP_W-1:0]         lo_r_in;
   logic [PP_W-1:0]         lo_i_in;
   logic signed [PP_W-1:0]  hi_r_ff;
   logic signed [PP_W-1:0]  hi_i_ff;
   logic [PP_W-1:0]         lo_r_ff;
   logic [PP_W-1:0]         lo_i_ff;
   logic                    s4_vld_ff;
   logic                    s4_reg_ff;

   assign scale_s = $signed({1'b0, inv_ff});
   assign hi_r_in = $signed(pr_ff[P_W-1:PLO_W]) * scale_s;
   assign hi_i_in = $signed(pi_ff[P_W-1:PLO_W]) * scale_s;
   assign lo_r_in = pr_ff[PLO_W-1:0] * inv_ff;
   assign lo_i_in = pi_ff[PLO_W-1:0] * inv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hi_r_ff   <= hi_r_in;
         hi_i_ff   <= hi_i_in;
         lo_r_ff   <= lo_r_in;
         lo_i_ff   <= lo_i_in;
         s4_reg_ff <= s3_reg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: recombine and take the floor of the Q16 shift
   // ---------------------------------------------------------------------------
   logic signed [SUM_W-1:0] sum_r;
   logic signed [SUM_W-1:0] sum_i;
   logic signed [Q_W-1:0]   q_re_ff;
   logic signed [Q_W-1:0]   q_im_ff;
   logic                    s5_vld_ff;
   logic                    s5_reg_ff;

   assign sum_r = (SUM_W'(hi_r_ff) <<< PLO_W) + SUM_W'(lo_r_ff);
   assign sum_i = (SUM_W'(hi_i_ff) <<< PLO_W) + SUM_W'(lo_i_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         q_re_ff   <= sum_r[SUM_W-1:SHR];
         q_im_ff   <= sum_i[SUM_W-1:SHR];
         s5_reg_ff <= s4_reg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: clip to 48 bits, zero out-of-region answers, response register
   // ---------------------------------------------------------------------------
   logic                    ovf_re;
   logic                    ovf_im;
   logic signed [OUT_W-1:0] clip_re;
   logic signed [OUT_W-1:0] clip_im;
   logic signed [OUT_W-1:0] out_re_in;
   logic signed [OUT_W-1:0] out_im_in;
   logic                    out_sat_in;
   logic signed [OUT_W-1:0] out_re_ff;
   logic signed [OUT_W-1:0] out_im_ff;
   logic                    out_sat_ff;
   logic                    out_reg_ff;

   // The value fits when all bits above the 48-bit sign agree with it.
   assign ovf_re  = !((&q_re_ff[Q_W-1:OUT_W-1]) || !(|q_re_ff[Q_W-1:OUT_W-1]));
   assign ovf_im  = !((&q_im_ff[Q_W-1:OUT_W-1]) || !(|q_im_ff[Q_W-1:OUT_W-1]));
   assign clip_re = ovf_re ? (q_re_ff[Q_W-1] ? OUT_MIN : OUT_MAX) : q_re_ff[OUT_W-1:0];
   assign clip_im = ovf_im ? (q_im_ff[Q_W-1] ? OUT_MIN : OUT_MAX) : q_im_ff[OUT_W-1:0];

   assign out_re_in  = s5_reg_ff ? clip_re : '0;
   assign out_im_in  = s5_reg_ff ? clip_im : '0;
   assign out_sat_in = s5_reg_ff && (ovf_re || ovf_im);

   always_ff @(posedge clock) begin
      if (adv) begin
         out_re_ff  <= out_re_in;
         out_im_ff  <= out_im_in;
         out_sat_ff <= out_sat_in;
         out_reg_ff <= s5_reg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= s5_vld_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {out_im_ff, out_re_ff};
   assign rsp_tuser  = {out_sat_ff, out_reg_ff};

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `BTP_ASSERT_IMPL(a_outside_zero, rsp_tvalid && !rsp_tuser[0], (rsp_tdata == '0) && !rsp_tuser[1])
   `BTP_ASSERT_IMPL(a_sat_clipped, rsp_tvalid && rsp_tuser[1], (out_re_ff == OUT_MAX) || (out_re_ff == OUT_MIN) || (out_im_ff == OUT_MAX) || (out_im_ff == OUT_MIN))
   `BTP_ASSERT_NEXT(a_query_enters, req_tready, s1_vld_ff == $past(req_tvalid && (op == OP_QUERY)))
   `BTP_ASSERT_NEXT(a_stall_holds, !adv && s5_vld_ff, s5_vld_ff && $stable(q_re_ff) && $stable(q_im_ff))

endmodule
